FILE: hdl/gsn_pkg.sv
package gsn_pkg;

  // divider operand widths
  localparam int DIV_W = 24;
  localparam int DVS_W = 16;
  // bin accumulator width
  localparam int ACC_W = 26;

  localparam logic [1:0] ST_BIN   = 2'd0;
  localparam logic [1:0] ST_LONG  = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;

  localparam logic REG_THRESH = 1'b0;
  localparam logic REG_MINLEN = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_SCAN, S_DECIDE, S_AVG_GO, S_AVG_WAIT, S_PREP, S_BIN_GO,
    S_BIN_DIV, S_BIN_WAIT, S_SMP, S_SCALE_GO, S_SCALE_WAIT, S_SHARE_GO,
    S_SHARE_WAIT, S_EMIT
  } state_e;

  typedef enum logic [1:0] {PH_FILL, PH_QUIET, PH_ONSET, PH_REC} phase_e;

  typedef enum logic [1:0] {DV_AVG, DV_BOUND, DV_SCALE, DV_SHARE} div_sel_e;

  typedef struct packed {
    logic       capture;
    logic       win_write;
    logic       fill_inc;
    logic       scan_start;
    logic       restart;
    logic       div_start;
    div_sel_e   div_sel;
    logic       axis_clr;
    logic       axis_inc;
    logic       onset_latch;
    logic       rec_store;
    logic       prep;
    logic       bin_begin;
    logic       smp_read;
    logic       smp_next;
    logic       emit_rej;
    logic [1:0] rej_code;
    logic       emit_bin;
  } cmd_t;

  typedef struct packed {
    logic scan_busy;
    logic motion;
    logic fill_last;
    logic rec_full;
    logic too_short;
    logic div_done;
    logic axis_last;
    logic smp_more;
    logic bin_last;
  } sts_t;

endpackage

FILE: hdl/gesture_segment_normalizer_unit.sv
// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+--------------------------------------
// sample    | in        | start, accepted when !busy| sample_x_i, sample_y_i, sample_z_i
// result    | out       | result_valid_o, one cycle | status_o, bin_number_o, x/y/z_level_o,
//           |           |                           | last_o
// config    | in        | apb write access cycle    | paddr, pwdata (prdata on reads)
//
// a sample transaction during window fill passes through S_WRITE only; otherwise the window scan
// sets the cost, reading every window slot through the single window read port
// onset and end of motion add three averages by reciprocal multiply
// each bin then takes a bound division plus six serial divisions per trace sample (scale, share)
// reset clears control state and loads the two registers' defaults; stores are undefined until written
// the result side cannot stall; results come out spaced by the divider loop
module gesture_segment_normalizer_unit import gsn_pkg::*; #(
  parameter int WINDOW_DEPTH = 16,
  parameter int TRACE_DEPTH  = 256,
  parameter int BIN_COUNT    = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // sample transaction
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] sample_x_i,
  input  logic signed [15:0] sample_y_i,
  input  logic signed [15:0] sample_z_i,
  // result transaction
  output logic               result_valid_o,
  output logic [1:0]         status_o,
  output logic [4:0]         bin_number_o,
  output logic [7:0]         x_level_o,
  output logic [7:0]         y_level_o,
  output logic [7:0]         z_level_o,
  output logic               last_o,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [17:0] thresh_q;
  logic [7:0]  min_len_q;
  logic        cfg_wr;
  cmd_t        cmd;
  sts_t        sts;

  // register writes land in the access cycle
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q  <= 18'd2000;
      min_len_q <= 8'd16;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_THRESH) thresh_q <= pwdata[17:0];
      else min_len_q <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_MINLEN) ? 32'(min_len_q) : 32'(thresh_q);

  // phase sequencing and divider scheduling
  gsn_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // window, trace store, peaks and bin arithmetic
  gsn_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .TRACE_DEPTH  (TRACE_DEPTH),
    .BIN_COUNT    (BIN_COUNT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .sample_x_i     (sample_x_i),
    .sample_y_i     (sample_y_i),
    .sample_z_i     (sample_z_i),
    .thresh_i       (thresh_q),
    .min_len_i      (min_len_q),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .bin_number_o   (bin_number_o),
    .x_level_o      (x_level_o),
    .y_level_o      (y_level_o),
    .z_level_o      (z_level_o),
    .last_o         (last_o)
  );

  // an accepted sample always raises busy in the cycle after it is taken
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted sample did not raise busy");

  // results are never emitted in consecutive cycles
  a_res_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("back to back results");

  // a reject is a single closing result with bin zero
  a_reject_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o != ST_BIN |-> last_o && bin_number_o == 5'd0)
    else $error("malformed reject");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> status_o == ST_BIN || status_o == ST_LONG || status_o == ST_SHORT)
    else $error("bad status code");

endmodule

FILE: hdl/gsn_div.sv
module gsn_div import gsn_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DIV_W-1:0] dividend_i,
  input  logic [DVS_W-1:0]        divisor_i,
  output logic                    done_o,
  output logic signed [DIV_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q, neg_q;
  logic [DIV_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q, dvs_q;
  logic [DVS_W:0]   rem_sh;
  logic             fits;

  // restoring division on magnitudes, one quotient bit per cycle
  assign rem_sh = {rem_q, quo_q[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DIV_W-1];
      quo_q <= dividend_i[DIV_W-1] ? DIV_W'(-dividend_i) : DIV_W'(dividend_i);
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? DVS_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DVS_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

FILE: hdl/gsn_datapath.sv
module gsn_datapath import gsn_pkg::*; #(
  parameter int WINDOW_DEPTH = 16,
  parameter int TRACE_DEPTH  = 256,
  parameter int BIN_COUNT    = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic signed [15:0] sample_x_i,
  input  logic signed [15:0] sample_y_i,
  input  logic signed [15:0] sample_z_i,
  input  logic [17:0]        thresh_i,
  input  logic [7:0]         min_len_i,
  output logic               result_valid_o,
  output logic [1:0]         status_o,
  output logic [4:0]         bin_number_o,
  output logic [7:0]         x_level_o,
  output logic [7:0]         y_level_o,
  output logic [7:0]         z_level_o,
  output logic               last_o
);

  localparam int WA_W  = $clog2(WINDOW_DEPTH);
  localparam int TA_W  = $clog2(TRACE_DEPTH);
  localparam int TL_W  = $clog2(TRACE_DEPTH + 1);
  localparam int BI_W  = $clog2(BIN_COUNT);
  localparam int SUM_W = 16 + WA_W;
  localparam int CW    = ((TL_W > 9) ? TL_W : 9) + 1;

  // division by the window depth or the bin count: reciprocal multiply on the magnitude
  localparam int CQ_W  = DIV_W;
  localparam int AVG_S = CQ_W + $clog2(WINDOW_DEPTH);
  localparam int BND_S = CQ_W + $clog2(BIN_COUNT);
  localparam logic [CQ_W:0] AVG_M = (CQ_W + 1)'((64'd1 << AVG_S) / WINDOW_DEPTH + 1);
  localparam logic [CQ_W:0] BND_M = (CQ_W + 1)'((64'd1 << BND_S) / BIN_COUNT + 1);

  function automatic logic signed [15:0] axis_sel(logic [47:0] w, logic [1:0] a);
    logic signed [15:0] r;
    unique case (a)
      2'd0:    r = w[47:32];
      2'd1:    r = w[31:16];
      default: r = w[15:0];
    endcase
    return r;
  endfunction

  function automatic logic [7:0] sat8(logic signed [ACC_W-1:0] v);
    logic [7:0] r;
    if (v < 0) r = 8'd0;
    else if (v > ACC_W'(255)) r = 8'd255;
    else r = v[7:0];
    return r;
  endfunction

  // window store and scan
  logic [47:0]             win_mem [WINDOW_DEPTH];
  logic [47:0]             win_rd_q;
  logic [WA_W-1:0]         slot_q, scan_cnt_q, fill_q;
  logic                    scan_act_q, scan_vld_q, scan_first_q;
  logic signed [SUM_W-1:0] sum_q [3];
  logic signed [15:0]      mx_q [3], mn_q [3];
  logic [15:0]             rng [3];
  logic [17:0]             rng_sum;

  // gesture state
  logic signed [15:0] samp_q [3];
  logic signed [15:0] avg_q [3], onset_q [3], hi_q [3], lo_q [3], center_q [3];
  logic [TL_W-1:0]    tlen_q, len_q, j_q, k_q, s_q;
  logic [47:0]        tr_mem [TRACE_DEPTH];
  logic [47:0]        tr_rd_q;
  logic [1:0]         axis_q;
  logic [BI_W-1:0]    i_q;
  logic [DIV_W-1:0]   num_q;
  logic signed [DIV_W-1:0] t_q;
  logic signed [ACC_W-1:0] acc_q [3];
  logic [15:0]        spread, spread_q;
  logic signed [16:0] csum [3], chalf [3];

  // divider hookup
  div_sel_e                div_sel_q;
  logic signed [DIV_W-1:0] dvd, quo;
  logic [DVS_W-1:0]        dvs;
  logic                    div_done;
  logic signed [16:0]      dscale;
  logic signed [15:0]      tr_v;

  // constant divisor path
  logic                    cdiv_sel, cdiv_done_q;
  logic [CQ_W-1:0]         cmag, cqmag;
  logic [CQ_W:0]           cmul;
  logic [2*CQ_W:0]         cprod;
  logic signed [DIV_W-1:0] cquo_q, squo;
  logic                    sdiv_done;

  always_ff @(posedge clk_i) begin
    if (cmd_i.win_write) win_mem[slot_q] <= {samp_q[0], samp_q[1], samp_q[2]};
    if (scan_act_q) win_rd_q <= win_mem[scan_cnt_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rec_store) tr_mem[tlen_q[TA_W-1:0]] <= {samp_q[0], samp_q[1], samp_q[2]};
    if (cmd_i.smp_read) tr_rd_q <= tr_mem[s_q[TA_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q       <= '0;
      fill_q       <= '0;
      scan_cnt_q   <= '0;
      scan_act_q   <= 1'b0;
      scan_vld_q   <= 1'b0;
      scan_first_q <= 1'b0;
      tlen_q       <= '0;
      axis_q       <= '0;
    end else begin
      if (cmd_i.restart) begin
        slot_q <= '0;
        fill_q <= '0;
      end else begin
        if (cmd_i.win_write)
          slot_q <= (slot_q == WA_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;
        if (cmd_i.fill_inc) fill_q <= fill_q + 1'b1;
      end
      scan_vld_q <= scan_act_q;
      if (cmd_i.scan_start) begin
        scan_act_q <= 1'b1;
        scan_cnt_q <= '0;
      end else if (scan_act_q) begin
        scan_cnt_q <= scan_cnt_q + 1'b1;
        if (scan_cnt_q == WA_W'(WINDOW_DEPTH - 1)) scan_act_q <= 1'b0;
      end
      if (cmd_i.scan_start) scan_first_q <= 1'b1;
      else if (scan_vld_q) scan_first_q <= 1'b0;
      if (cmd_i.onset_latch) tlen_q <= '0;
      else if (cmd_i.rec_store) tlen_q <= tlen_q + 1'b1;
      if (cmd_i.axis_clr) axis_q <= '0;
      else if (cmd_i.axis_inc) axis_q <= axis_q + 1'b1;
    end
  end

  // min, max and sum per axis, one slot a cycle
  always_ff @(posedge clk_i) begin
    if (scan_vld_q) begin
      for (int a = 0; a < 3; a++) begin
        if (scan_first_q) begin
          sum_q[a] <= SUM_W'(axis_sel(win_rd_q, 2'(a)));
          mx_q[a]  <= axis_sel(win_rd_q, 2'(a));
          mn_q[a]  <= axis_sel(win_rd_q, 2'(a));
        end else begin
          sum_q[a] <= sum_q[a] + SUM_W'(axis_sel(win_rd_q, 2'(a)));
          if (axis_sel(win_rd_q, 2'(a)) > mx_q[a]) mx_q[a] <= axis_sel(win_rd_q, 2'(a));
          if (axis_sel(win_rd_q, 2'(a)) < mn_q[a]) mn_q[a] <= axis_sel(win_rd_q, 2'(a));
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rng[a]   = 16'(17'(mx_q[a]) - 17'(mn_q[a]));
      csum[a]  = 17'(onset_q[a]) + 17'(avg_q[a]);
      chalf[a] = $signed(csum[a] + 17'(csum[a][16])) >>> 1;
    end
    rng_sum = 18'(rng[0]) + 18'(rng[1]) + 18'(rng[2]);
  end

  // largest peak range, zero taken as one
  always_comb begin
    logic [15:0] r0, r1, r2, m;
    r0 = 16'(17'(hi_q[0]) - 17'(lo_q[0]));
    r1 = 16'(17'(hi_q[1]) - 17'(lo_q[1]));
    r2 = 16'(17'(hi_q[2]) - 17'(lo_q[2]));
    m  = (r0 > r1) ? r0 : r1;
    m  = (r2 > m) ? r2 : m;
    spread = (m == 16'd0) ? 16'd1 : m;
  end

  assign tr_v   = axis_sel(tr_rd_q, axis_q);
  assign dscale = 17'(tr_v) - 17'(center_q[axis_q]);

  always_comb begin
    unique case (cmd_i.div_sel)
      DV_AVG: begin
        dvd = DIV_W'(sum_q[axis_q]);
        dvs = DVS_W'(WINDOW_DEPTH);
      end
      DV_BOUND: begin
        dvd = num_q;
        dvs = DVS_W'(BIN_COUNT);
      end
      DV_SCALE: begin
        dvd = {dscale, 7'b0};
        dvs = spread_q;
      end
      default: begin
        dvd = t_q;
        dvs = DVS_W'(k_q - j_q);
      end
    endcase
  end

  // averages and bin bounds: combinational reciprocal multiplier, quotient registered
  always_comb begin
    cdiv_sel = (cmd_i.div_sel == DV_AVG) || (cmd_i.div_sel == DV_BOUND);
    cmag     = dvd[DIV_W-1] ? CQ_W'(-dvd) : CQ_W'(dvd);
    cmul     = (cmd_i.div_sel == DV_AVG) ? AVG_M : BND_M;
    cprod    = (2 * CQ_W + 1)'(cmag) * (2 * CQ_W + 1)'(cmul);
    cqmag    = (cmd_i.div_sel == DV_AVG) ? CQ_W'(cprod >> AVG_S) : CQ_W'(cprod >> BND_S);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cdiv_done_q <= 1'b0;
    else cdiv_done_q <= cmd_i.div_start & cdiv_sel;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start && cdiv_sel)
      cquo_q <= dvd[DIV_W-1] ? -$signed(cqmag) : $signed(cqmag);
  end

  // scale and share divisions by data go through the serial divider
  gsn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start & ~cdiv_sel),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (sdiv_done),
    .quotient_o (squo)
  );

  assign div_done = sdiv_done | cdiv_done_q;
  assign quo      = cdiv_done_q ? cquo_q : squo;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      samp_q[0] <= sample_x_i;
      samp_q[1] <= sample_y_i;
      samp_q[2] <= sample_z_i;
    end
    if (cmd_i.div_start) div_sel_q <= cmd_i.div_sel;
    for (int a = 0; a < 3; a++) begin
      if (cmd_i.onset_latch) begin
        // the last axis average lands in this same cycle
        onset_q[a] <= (2'(a) == axis_q) ? quo[15:0] : avg_q[a];
        hi_q[a]    <= samp_q[a];
        lo_q[a]    <= samp_q[a];
      end else if (cmd_i.rec_store) begin
        if (samp_q[a] > hi_q[a]) hi_q[a] <= samp_q[a];
        if (samp_q[a] < lo_q[a]) lo_q[a] <= samp_q[a];
      end
      if (cmd_i.prep) center_q[a] <= chalf[a][15:0];
      if (cmd_i.bin_begin) acc_q[a] <= ACC_W'(128);
    end
    if (cmd_i.prep) begin
      spread_q <= spread;
      len_q    <= tlen_q - TL_W'(WINDOW_DEPTH);
      num_q    <= '0;
      k_q      <= '0;
      i_q      <= '0;
    end
    if (cmd_i.bin_begin) begin
      num_q <= num_q + DIV_W'(len_q);
      j_q   <= k_q;
      s_q   <= k_q;
    end
    if (cmd_i.smp_next) s_q <= s_q + 1'b1;
    if (cmd_i.emit_bin) i_q <= i_q + 1'b1;
    if (div_done) begin
      unique case (div_sel_q)
        DV_AVG:   avg_q[axis_q] <= quo[15:0];
        DV_BOUND: k_q <= quo[TL_W-1:0];
        DV_SCALE: t_q <= quo;
        default:  acc_q[axis_q] <= acc_q[axis_q] + ACC_W'(quo);
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) result_valid_o <= 1'b0;
    else result_valid_o <= cmd_i.emit_rej | cmd_i.emit_bin;
  end

  always_ff @(posedge clk_i) begin
    logic [BI_W+4:0] iext;
    iext = (BI_W + 5)'(i_q);
    if (cmd_i.emit_rej) begin
      status_o     <= cmd_i.rej_code;
      bin_number_o <= 5'd0;
      x_level_o    <= 8'd0;
      y_level_o    <= 8'd0;
      z_level_o    <= 8'd0;
      last_o       <= 1'b1;
    end else if (cmd_i.emit_bin) begin
      status_o     <= ST_BIN;
      bin_number_o <= iext[4:0];
      x_level_o    <= sat8(acc_q[0]);
      y_level_o    <= sat8(acc_q[1]);
      z_level_o    <= sat8(acc_q[2]);
      last_o       <= (i_q == BI_W'(BIN_COUNT - 1));
    end
  end

  assign sts_o.scan_busy = scan_act_q | scan_vld_q;
  assign sts_o.motion    = rng_sum > thresh_i;
  assign sts_o.fill_last = fill_q == WA_W'(WINDOW_DEPTH - 1);
  assign sts_o.rec_full  = tlen_q == TL_W'(TRACE_DEPTH - 1);
  assign sts_o.too_short = CW'(tlen_q) < CW'(WINDOW_DEPTH) + CW'(min_len_i);
  assign sts_o.div_done  = div_done;
  assign sts_o.axis_last = axis_q == 2'd2;
  assign sts_o.smp_more  = s_q < k_q;
  assign sts_o.bin_last  = i_q == BI_W'(BIN_COUNT - 1);

endmodule

FILE: hdl/gsn_ctrl.sv
module gsn_ctrl import gsn_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_FILL;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    unique case (state_q)
      S_IDLE:  if (start) state_d = S_WRITE;
      S_WRITE: begin
        if (phase_q == PH_FILL) begin
          if (sts_i.fill_last) phase_d = PH_QUIET;
          state_d = S_IDLE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN:  if (!sts_i.scan_busy) state_d = S_DECIDE;
      S_DECIDE: begin
        state_d = S_IDLE;
        unique case (phase_q)
          PH_QUIET: if (!sts_i.motion) phase_d = PH_ONSET;
          PH_ONSET: if (sts_i.motion) state_d = S_AVG_GO;
          PH_REC: begin
            if (sts_i.motion) begin
              if (sts_i.rec_full) phase_d = PH_FILL;
            end else if (sts_i.too_short) begin
              phase_d = PH_FILL;
            end else begin
              state_d = S_AVG_GO;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_AVG_GO: state_d = S_AVG_WAIT;
      S_AVG_WAIT: begin
        if (sts_i.div_done) begin
          if (!sts_i.axis_last) begin
            state_d = S_AVG_GO;
          end else if (phase_q == PH_ONSET) begin
            phase_d = PH_REC;
            state_d = S_IDLE;
          end else begin
            state_d = S_PREP;
          end
        end
      end
      S_PREP:     state_d = S_BIN_GO;
      S_BIN_GO:   state_d = S_BIN_DIV;
      S_BIN_DIV:  state_d = S_BIN_WAIT;
      S_BIN_WAIT: if (sts_i.div_done) state_d = S_SMP;
      S_SMP:      state_d = sts_i.smp_more ? S_SCALE_GO : S_EMIT;
      S_SCALE_GO: state_d = S_SCALE_WAIT;
      S_SCALE_WAIT: if (sts_i.div_done) state_d = S_SHARE_GO;
      S_SHARE_GO: state_d = S_SHARE_WAIT;
      S_SHARE_WAIT: begin
        if (sts_i.div_done) state_d = sts_i.axis_last ? S_SMP : S_SCALE_GO;
      end
      S_EMIT: begin
        if (sts_i.bin_last) begin
          phase_d = PH_FILL;
          state_d = S_IDLE;
        end else begin
          state_d = S_BIN_GO;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    cmd_o.div_sel = DV_AVG;
    unique case (state_q)
      S_IDLE:  cmd_o.capture = start;
      S_WRITE: begin
        cmd_o.win_write  = 1'b1;
        cmd_o.fill_inc   = (phase_q == PH_FILL);
        cmd_o.scan_start = (phase_q != PH_FILL);
      end
      S_DECIDE: begin
        cmd_o.axis_clr = 1'b1;
        if (phase_q == PH_REC) begin
          if (sts_i.motion) begin
            cmd_o.rec_store = 1'b1;
            if (sts_i.rec_full) begin
              cmd_o.emit_rej = 1'b1;
              cmd_o.rej_code = ST_LONG;
              cmd_o.restart  = 1'b1;
            end
          end else if (sts_i.too_short) begin
            cmd_o.emit_rej = 1'b1;
            cmd_o.rej_code = ST_SHORT;
            cmd_o.restart  = 1'b1;
          end
        end
      end
      S_AVG_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DV_AVG;
      end
      S_AVG_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.axis_inc    = !sts_i.axis_last;
          cmd_o.onset_latch = sts_i.axis_last && (phase_q == PH_ONSET);
        end
      end
      S_PREP:   cmd_o.prep = 1'b1;
      S_BIN_GO: cmd_o.bin_begin = 1'b1;
      S_BIN_DIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DV_BOUND;
      end
      S_SMP: begin
        cmd_o.axis_clr = 1'b1;
        cmd_o.smp_read = sts_i.smp_more;
      end
      S_SCALE_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DV_SCALE;
      end
      S_SHARE_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DV_SHARE;
      end
      S_SHARE_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.axis_inc = !sts_i.axis_last;
          cmd_o.smp_next = sts_i.axis_last;
        end
      end
      S_EMIT: begin
        cmd_o.emit_bin = 1'b1;
        cmd_o.restart  = sts_i.bin_last;
      end
      default: cmd_o.capture = 1'b0;
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule
